### sv/adc_to_dac_biquad_lowpass_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ADC to DAC biquad low-pass block.
// Every macro samples on the rising edge of clk and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ADC_TO_DAC_BIQUAD_LOWPASS_TOP_MACROS_SVH
`define ADC_TO_DAC_BIQUAD_LOWPASS_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADBQ_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADBQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/adbq_pkg.sv
// ----------------------------------------------------------------------------
// adbq_pkg
// Shared types and constants of the ADC to DAC biquad low-pass block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adbq_pkg;

    // Field widths.
    localparam int CODE_W = 12;
    localparam int COEF_W = 32;
    localparam int X_W    = 16;
    localparam int Y_W    = 32;
    localparam int IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_COEF_B0    = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_B1    = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_B2    = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_A1    = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_A2    = 3'd4;
    localparam logic [IDX_W-1:0] REG_ADC_OFFSET = 3'd5;
    localparam logic [IDX_W-1:0] REG_DAC_OFFSET = 3'd6;

    // Reset values of the registers (b0 is 1.0 in Q2.30).
    localparam logic [COEF_W-1:0] COEF_ONE     = 32'h4000_0000;
    localparam logic [CODE_W-1:0] CODE_MIDDLE  = 12'd2048;
    localparam logic [CODE_W-1:0] DAC_CODE_MAX = 12'd4095;

    // Biquad coefficient set, all signed Q2.30.
    typedef struct packed {
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
    } coef_set_t;

    // Control from the handshake stage to the filter stage.
    typedef struct packed {
        logic step;
        logic clear;
    } filt_ctrl_t;

endpackage

### sv/adbq_filter.sv
// ----------------------------------------------------------------------------
// adbq_filter
// Direct form 1 biquad section with its history and the DAC code register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adbq_filter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  adbq_pkg::filt_ctrl_t              ctrl,
    input  logic signed [adbq_pkg::X_W-1:0]   x,
    input  adbq_pkg::coef_set_t               coefs,
    input  logic [adbq_pkg::CODE_W-1:0]       dac_offset,
    output logic [adbq_pkg::CODE_W-1:0]       dac_code
);

    localparam int FF_W  = adbq_pkg::COEF_W + adbq_pkg::X_W;   // feedforward product
    localparam int FB_W  = adbq_pkg::COEF_W + adbq_pkg::Y_W;   // feedback product
    localparam int FBS_W = FB_W - 8;                           // feedback at 30 fraction bits
    localparam int ACC_W = FBS_W + 3;                          // room for five terms
    localparam int YW_W  = ACC_W - 22;                         // sum at 8 fraction bits
    localparam int Q_W   = adbq_pkg::Y_W - 8;                  // integer part of y
    localparam int SUM_W = Q_W + 1;

    // History registers.
    logic signed [adbq_pkg::X_W-1:0] x1_reg, x2_reg;
    logic signed [adbq_pkg::Y_W-1:0] y1_reg, y2_reg;
    logic [adbq_pkg::CODE_W-1:0]     dac_code_reg;

    logic signed [adbq_pkg::X_W-1:0] x1_use, x2_use;
    logic signed [adbq_pkg::Y_W-1:0] y1_use, y2_use;
    logic signed [FF_W-1:0]          p_b0, p_b1, p_b2;
    logic signed [FB_W-1:0]          p_a1, p_a2;
    logic signed [FBS_W-1:0]         f_a1, f_a2;
    logic signed [ACC_W-1:0]         acc;
    logic signed [YW_W-1:0]          y_wide;
    logic signed [adbq_pkg::Y_W-1:0] y_next;
    logic signed [Q_W-1:0]           q_trunc;
    logic signed [SUM_W-1:0]         o_sum;
    logic [adbq_pkg::CODE_W-1:0]     dac_code_next;

    // A clear request zeroes the history before this sample is used.
    assign x1_use = ctrl.clear ? '0 : x1_reg;
    assign x2_use = ctrl.clear ? '0 : x2_reg;
    assign y1_use = ctrl.clear ? '0 : y1_reg;
    assign y2_use = ctrl.clear ? '0 : y2_reg;

    // Five parallel products.
    assign p_b0 = $signed(coefs.b0) * x;
    assign p_b1 = $signed(coefs.b1) * x1_use;
    assign p_b2 = $signed(coefs.b2) * x2_use;
    assign p_a1 = $signed(coefs.a1) * y1_use;
    assign p_a2 = $signed(coefs.a2) * y2_use;

    // Dropping the low bits of a feedback product rounds toward minus infinity.
    assign f_a1 = p_a1[FB_W-1:8];
    assign f_a2 = p_a2[FB_W-1:8];

    // Exact sum of the five terms at 30 fraction bits.
    assign acc = {{(ACC_W-FF_W){p_b0[FF_W-1]}}, p_b0}
               + {{(ACC_W-FF_W){p_b1[FF_W-1]}}, p_b1}
               + {{(ACC_W-FF_W){p_b2[FF_W-1]}}, p_b2}
               + {{(ACC_W-FBS_W){f_a1[FBS_W-1]}}, f_a1}
               + {{(ACC_W-FBS_W){f_a2[FBS_W-1]}}, f_a2};

    // Floor to 8 fraction bits and saturate to the 32-bit history format.
    assign y_wide = acc[ACC_W-1:22];

    always_comb
    begin
        if (y_wide[YW_W-1:adbq_pkg::Y_W-1] == '0 || y_wide[YW_W-1:adbq_pkg::Y_W-1] == '1)
        begin
            y_next = y_wide[adbq_pkg::Y_W-1:0];
        end
        else if (y_wide[YW_W-1])
        begin
            y_next = {1'b1, {(adbq_pkg::Y_W-1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(adbq_pkg::Y_W-1){1'b1}}};
        end
    end

    // Integer part truncated toward zero, then the DAC midpoint and the clamp.
    // Any value beyond 16 bits lands outside 0..4095 either way.
    always_comb
    begin
        q_trunc = y_next[adbq_pkg::Y_W-1:8];
        if (y_next[adbq_pkg::Y_W-1] && (y_next[7:0] != '0))
        begin
            q_trunc = q_trunc + Q_W'(1);
        end
        o_sum = {q_trunc[Q_W-1], q_trunc}
              + {{(SUM_W-adbq_pkg::CODE_W){1'b0}}, dac_offset};
        if (o_sum[SUM_W-1] || (o_sum == '0))
        begin
            dac_code_next = '0;
        end
        else if (o_sum >= $signed({{(SUM_W-adbq_pkg::CODE_W){1'b0}}, adbq_pkg::DAC_CODE_MAX}))
        begin
            dac_code_next = adbq_pkg::DAC_CODE_MAX;
        end
        else
        begin
            dac_code_next = o_sum[adbq_pkg::CODE_W-1:0];
        end
    end

    // History shifts once per processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (ctrl.step)
        begin
            x1_reg <= x;
            x2_reg <= x1_use;
            y1_reg <= y_next;
            y2_reg <= y1_use;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            dac_code_reg <= dac_code_next;
        end
    end

    assign dac_code = dac_code_reg;

endmodule

### sv/adc_to_dac_biquad_lowpass_top.sv
// ----------------------------------------------------------------------------
// adc_to_dac_biquad_lowpass_top
// ADC code in, one biquad low-pass section, DAC code out.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+------------------------------
//  input    | in_valid, in_stall | adc_code, clear_history
//  output   | out_valid,out_stall| dac_code
//  config   | cfg_write          | cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low; each passes the input
// register, then the biquad into the result register, where out_valid offers it.
// The biquad sum is combinational, through five parallel multipliers.
// Reset sets the coefficients to a pass-through and zeroes the history.
// A stalled result holds in the output register; one more request may wait
// in the input register before in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "adc_to_dac_biquad_lowpass_top_macros.svh"

module adc_to_dac_biquad_lowpass_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_write,
    input  logic [adbq_pkg::IDX_W-1:0]        cfg_index,
    input  logic [adbq_pkg::COEF_W-1:0]       cfg_data,
    // Input channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [adbq_pkg::CODE_W-1:0]       adc_code,
    input  logic                              clear_history,
    // Output channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [adbq_pkg::CODE_W-1:0]       dac_code
);

    // Configuration registers.
    adbq_pkg::coef_set_t              coefs_reg;
    logic [adbq_pkg::CODE_W-1:0]      adc_offset_reg;
    logic [adbq_pkg::CODE_W-1:0]      dac_offset_reg;

    // Input stage.
    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic signed [adbq_pkg::X_W-1:0]  s1_x_reg;
    logic                             s1_clear_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;

    logic                             in_accept;
    logic                             advance;
    logic signed [adbq_pkg::CODE_W:0] x_diff;
    adbq_pkg::filt_ctrl_t             filt_ctrl;

    // Register writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.b0   <= adbq_pkg::COEF_ONE;
            coefs_reg.b1   <= '0;
            coefs_reg.b2   <= '0;
            coefs_reg.a1   <= '0;
            coefs_reg.a2   <= '0;
            adc_offset_reg <= adbq_pkg::CODE_MIDDLE;
            dac_offset_reg <= adbq_pkg::CODE_MIDDLE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                adbq_pkg::REG_COEF_B0:    coefs_reg.b0   <= cfg_data;
                adbq_pkg::REG_COEF_B1:    coefs_reg.b1   <= cfg_data;
                adbq_pkg::REG_COEF_B2:    coefs_reg.b2   <= cfg_data;
                adbq_pkg::REG_COEF_A1:    coefs_reg.a1   <= cfg_data;
                adbq_pkg::REG_COEF_A2:    coefs_reg.a2   <= cfg_data;
                adbq_pkg::REG_ADC_OFFSET: adc_offset_reg <= cfg_data[adbq_pkg::CODE_W-1:0];
                adbq_pkg::REG_DAC_OFFSET: dac_offset_reg <= cfg_data[adbq_pkg::CODE_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Handshake: the input stage moves on whenever the output register is free.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Centered sample; the 13-bit difference always fits the 16-bit range.
    assign x_diff = $signed({1'b0, adc_code}) - $signed({1'b0, adc_offset_reg});

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg     <= {{(adbq_pkg::X_W-adbq_pkg::CODE_W-1){x_diff[adbq_pkg::CODE_W]}},
                             x_diff};
            s1_clear_reg <= clear_history;
        end
    end

    assign filt_ctrl.step  = advance;
    assign filt_ctrl.clear = s1_clear_reg;

    adbq_filter u_filter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (filt_ctrl),
        .x          (s1_x_reg),
        .coefs      (coefs_reg),
        .dac_offset (dac_offset_reg),
        .dac_code   (dac_code)
    );

    assign out_valid = out_valid_reg;

    // Checks on the two-stage flow.
    `ADBQ_ASSERT_NOW(a_no_bubble, s1_valid_reg && !out_valid_reg, !in_stall, "input stalled")
    `ADBQ_ASSERT_NEXT(a_accept_loads, in_accept, s1_valid_reg, "accepted request lost")
    `ADBQ_ASSERT_NEXT(a_advance_shows, advance, out_valid_reg, "result did not appear")

endmodule

### tb/dac_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_code_checker
// Watches the register port and both channels of the ADC to DAC biquad block.
// It keeps its own copy of the filter settings and history, works out the
// DAC code of every accepted request, and compares each result in order.
// ----------------------------------------------------------------------------

module dac_code_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [adbq_pkg::IDX_W-1:0]        cfg_index,
    input  logic [adbq_pkg::COEF_W-1:0]       cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [adbq_pkg::CODE_W-1:0]       adc_code,
    input  logic                              clear_history,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [adbq_pkg::CODE_W-1:0]       dac_code,
    output int                                mismatches,
    output int                                pending_results
);

    import adbq_pkg::*;

    localparam longint X_MIN = -64'sd32768;
    localparam longint X_MAX = 64'sd32767;
    localparam longint Y_MIN = -64'sd2147483648;
    localparam longint Y_MAX = 64'sd2147483647;

    // Mirror of the filter settings.
    logic signed [COEF_W-1:0] tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
    logic [CODE_W-1:0]        adc_mid, dac_mid;

    // Mirror of the filter history: integer samples and Q24.8 outputs.
    logic signed [X_W-1:0]    x_d1, x_d2;
    logic signed [Y_W-1:0]    y_d1, y_d2;

    // DAC codes still owed by the block, oldest first.
    logic [CODE_W-1:0]        expected_dac_q[$];

    int error_count = 0;

    assign mismatches = error_count;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // One biquad step: returns the DAC code and advances the history.
    function automatic logic [CODE_W-1:0] filter_step(input logic [CODE_W-1:0] code,
                                                      input logic clear);
        longint x;
        longint acc;
        longint y;
        longint o;
        if (clear)
        begin
            x_d1 = '0;
            x_d2 = '0;
            y_d1 = '0;
            y_d2 = '0;
        end
        x = clamp(longint'(code) - longint'(adc_mid), X_MIN, X_MAX);

        // Feedback products carry 38 fraction bits; floor them to 30.
        acc = longint'(tap_b0) * x
            + longint'(tap_b1) * longint'(x_d1)
            + longint'(tap_b2) * longint'(x_d2)
            + ((longint'(tap_a1) * longint'(y_d1)) >>> 8)
            + ((longint'(tap_a2) * longint'(y_d2)) >>> 8);
        y = clamp(acc >>> 22, Y_MIN, Y_MAX);

        x_d2 = x_d1;
        x_d1 = X_W'(x);
        y_d2 = y_d1;
        y_d1 = Y_W'(y);

        // Truncate toward zero, then offset and clamp to the DAC range.
        o = clamp(y / 256, X_MIN, X_MAX);
        o = clamp(o + longint'(dac_mid), X_MIN, X_MAX);
        o = clamp(o, 0, longint'(DAC_CODE_MAX));
        return CODE_W'(o);
    endfunction

    task automatic report_mismatch(input string what, input logic [CODE_W-1:0] got,
                                   input logic [CODE_W-1:0] want);
        $display("%0t ns: %s: dac_code %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Track register writes, check results, and predict new requests.
    always @(posedge clk or negedge rst_n)
    begin
        logic [CODE_W-1:0] want;
        if (!rst_n)
        begin
            tap_b0  = COEF_ONE;
            tap_b1  = '0;
            tap_b2  = '0;
            tap_a1  = '0;
            tap_a2  = '0;
            adc_mid = CODE_MIDDLE;
            dac_mid = CODE_MIDDLE;
            x_d1    = '0;
            x_d2    = '0;
            y_d1    = '0;
            y_d2    = '0;
            expected_dac_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_COEF_B0:    tap_b0  = cfg_data;
                    REG_COEF_B1:    tap_b1  = cfg_data;
                    REG_COEF_B2:    tap_b2  = cfg_data;
                    REG_COEF_A1:    tap_a1  = cfg_data;
                    REG_COEF_A2:    tap_a2  = cfg_data;
                    REG_ADC_OFFSET: adc_mid = cfg_data[CODE_W-1:0];
                    REG_DAC_OFFSET: dac_mid = cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_dac_q.size() == 0)
                    report_mismatch("result with no request pending", dac_code, 'x);
                else
                begin
                    want = expected_dac_q.pop_front();
                    if (dac_code !== want)
                        report_mismatch("wrong result", dac_code, want);
                end
            end

            if (in_valid && !in_stall)
                expected_dac_q.push_back(filter_step(adc_code, clear_history));

            pending_results <= expected_dac_q.size();
        end
    end

endmodule

### tb/adc_to_dac_biquad_lowpass_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_to_dac_biquad_lowpass_top_tb
// Drives ADC codes through the biquad block under random back-pressure.
// A directed pass covers full-scale codes, saturating and negative taps and
// history clears; random phases then load stable low-pass, small and fully
// random coefficient sets. The checker beside the block judges every result.
// ----------------------------------------------------------------------------

module adc_to_dac_biquad_lowpass_top_tb;

    import adbq_pkg::*;

    localparam int     CLK_HALF       = 4;
    localparam int     RESET_CYCLES   = 10;
    localparam int     PHASES         = 10;
    localparam int     PHASE_ITEMS    = 70;
    localparam int     HOLD_CYCLES    = 160;
    localparam int     SETTLE_CYCLES  = 4;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint Q30_ONE        = 64'sd1073741824;

    // How long a side waits before each request.
    typedef enum int {PACE_NONE, PACE_FULL, PACE_SHORT} pace_t;

    // Shape of the ADC code sequence within a phase.
    typedef enum int {WAVE_NOISE, WAVE_STEPS, WAVE_WALK} wave_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_write     = 1'b0;
    logic [IDX_W-1:0]    cfg_index     = '0;
    logic [COEF_W-1:0]   cfg_data      = '0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [CODE_W-1:0]   adc_code      = '0;
    logic                clear_history = 1'b0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [CODE_W-1:0]   dac_code;

    int                  mismatches;
    int                  pending_results;

    pace_t               tx_pace  = PACE_FULL;
    pace_t               rx_pace  = PACE_FULL;
    logic                hold_req = 1'b0;

    adc_to_dac_biquad_lowpass_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .adc_code      (adc_code),
        .clear_history (clear_history),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dac_code      (dac_code)
    );

    dac_code_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .adc_code        (adc_code),
        .clear_history   (clear_history),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .dac_code        (dac_code),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int draw_wait(input pace_t pace);
        case (pace)
            PACE_NONE:  return 0;
            PACE_SHORT: return $urandom_range(0, 3);
            default:    return $urandom_range(0, 19);
        endcase
    endfunction

    // Offer one request and return at the edge that accepts it.
    // Valid stays high after acceptance so back-to-back requests need no toggle.
    task automatic send_sample(input logic [CODE_W-1:0] code, input logic clr);
        int gap;
        gap = draw_wait(tx_pace);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        adc_code      <= code;
        clear_history <= clr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load all registers in one burst, then poke the unused index.
    task automatic program_filter(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                                  input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                                  input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] adc_word,
                                  input logic [COEF_W-1:0] dac_word);
        cfg_write <= 1'b1;
        cfg_index <= REG_COEF_B0;
        cfg_data  <= b0;
        @(posedge clk);
        cfg_index <= REG_COEF_B1;
        cfg_data  <= b1;
        @(posedge clk);
        cfg_index <= REG_COEF_B2;
        cfg_data  <= b2;
        @(posedge clk);
        cfg_index <= REG_COEF_A1;
        cfg_data  <= a1;
        @(posedge clk);
        cfg_index <= REG_COEF_A2;
        cfg_data  <= a2;
        @(posedge clk);
        cfg_index <= REG_ADC_OFFSET;
        cfg_data  <= adc_word;
        @(posedge clk);
        cfg_index <= REG_DAC_OFFSET;
        cfg_data  <= dac_word;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= $urandom();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off when asked for.
    initial
    begin
        int wait_cycles;
        int taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 50 == 0)
                rx_pace = pace_t'($urandom_range(0, 2));
            if (hold_req)
            begin
                wait_cycles = HOLD_CYCLES;
                hold_req    = 1'b0;
            end
            else
                wait_cycles = draw_wait(rx_pace);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Watchdog: ends the run when no request moves for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("adc_to_dac_biquad_lowpass_top: mismatch");
        $finish;
    end

    initial
    begin
        longint            r_q;
        longint            a1_q;
        longint            sum_q;
        logic [COEF_W-1:0] c_b0, c_b1, c_b2, c_a1, c_a2;
        logic [COEF_W-1:0] adc_word, dac_word;
        logic [CODE_W-1:0] level;
        wave_t             wave;
        int                run;
        int                kind;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings pass codes straight through around mid-scale.
        send_sample(12'd0, 1'b1);
        send_sample(DAC_CODE_MAX, 1'b0);
        send_sample(CODE_MIDDLE, 1'b0);
        send_sample(12'd2047, 1'b0);
        send_sample(12'd1, 1'b0);

        // Extreme taps drive y into saturation; offset upper bits are junk.
        settle();
        program_filter(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'hFFFF_F000, 32'h0000_0FFF);
        send_sample(DAC_CODE_MAX, 1'b0);
        send_sample(DAC_CODE_MAX, 1'b0);
        send_sample(DAC_CODE_MAX, 1'b0);
        send_sample(12'd0, 1'b0);
        send_sample(DAC_CODE_MAX, 1'b1);
        send_sample(12'd0, 1'b0);

        // Gain of minus two with a top-scale ADC offset; low codes clamp at the DAC top.
        settle();
        program_filter(32'h8000_0000, '0, '0, '0, '0, 32'h0000_0FFF, 32'hABCD_E000);
        send_sample(12'd0, 1'b0);
        send_sample(12'd4094, 1'b0);
        send_sample(DAC_CODE_MAX, 1'b0);
        send_sample(12'd2047, 1'b0);

        // Half gain on odd samples and fractional feedback exercise the
        // truncation toward zero and the floor of the feedback products.
        settle();
        program_filter(32'h2000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h4000_0001,
                       32'hC000_0000, {20'hFFFFF, CODE_MIDDLE}, {20'h0, CODE_MIDDLE});
        send_sample(12'd2047, 1'b1);
        send_sample(12'd2049, 1'b0);
        send_sample(12'd2045, 1'b0);
        send_sample(CODE_MIDDLE, 1'b0);
        send_sample(12'd3000, 1'b0);
        send_sample(12'd1000, 1'b0);

        // Random phases, each with its own coefficient set and pacing.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            kind = $urandom_range(0, 3);
            if (kind <= 1)
            begin
                // Stable low-pass with unity DC gain: poles from a2 = -r and
                // |a1| < 1 + r, zeros at z = -1.
                r_q  = $urandom_range(32'd322122547, 32'd1020054733);
                a1_q = $urandom_range(0, int'(((Q30_ONE + r_q) * 97) / 100));
                if ($urandom_range(0, 3) == 0)
                    a1_q = -a1_q;
                sum_q = Q30_ONE - a1_q + r_q;
                c_b0  = COEF_W'(sum_q / 4);
                c_b1  = COEF_W'(sum_q / 2);
                c_b2  = COEF_W'(sum_q / 4);
                c_a1  = COEF_W'(a1_q);
                c_a2  = COEF_W'(-r_q);
            end
            else if (kind == 2)
            begin
                c_b0 = COEF_W'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
                c_b1 = COEF_W'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
                c_b2 = COEF_W'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
                c_a1 = COEF_W'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
                c_a2 = COEF_W'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
            end
            else
            begin
                c_b0 = $urandom();
                c_b1 = $urandom();
                c_b2 = $urandom();
                c_a1 = $urandom();
                c_a2 = $urandom();
            end

            adc_word = $urandom();
            dac_word = $urandom();
            case ($urandom_range(0, 3))
                0:       adc_word[CODE_W-1:0] = '0;
                1:       adc_word[CODE_W-1:0] = DAC_CODE_MAX;
                2:       adc_word[CODE_W-1:0] = CODE_MIDDLE;
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0:       dac_word[CODE_W-1:0] = '0;
                1:       dac_word[CODE_W-1:0] = DAC_CODE_MAX;
                2:       dac_word[CODE_W-1:0] = CODE_MIDDLE;
                default: ;
            endcase
            program_filter(c_b0, c_b1, c_b2, c_a1, c_a2, adc_word, dac_word);

            // Two phases hold the result side off while requests keep coming.
            if (p == 3 || p == 7)
            begin
                tx_pace  = PACE_NONE;
                hold_req = 1'b1;
            end
            else
                tx_pace = pace_t'($urandom_range(0, 2));

            wave  = wave_t'($urandom_range(0, 2));
            level = CODE_W'($urandom());
            run   = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case (wave)
                    WAVE_NOISE:
                        level = CODE_W'($urandom());
                    WAVE_STEPS:
                    begin
                        if (run == 0)
                        begin
                            level = CODE_W'($urandom());
                            run   = $urandom_range(1, 20);
                        end
                        run--;
                    end
                    default:
                        level = level + CODE_W'($urandom_range(0, 64)) - 12'd32;
                endcase
                if ($urandom_range(0, 15) == 0)
                    level = $urandom_range(0, 1) ? DAC_CODE_MAX : '0;
                send_sample(level, $urandom_range(0, 31) == 0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("adc_to_dac_biquad_lowpass_top: match");
        else
            $display("adc_to_dac_biquad_lowpass_top: mismatch");
        $finish;
    end

endmodule
